[design/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;
  localparam int unsigned FIELD_W = 20;
  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned MIN_REMAINDER = 16;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_RESIZE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NULL   = 2'd1,
    ST_NOBLK  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;
endpackage
`default_nettype wire

[design/first_fit_heap_allocator_top.sv]
`default_nettype none
// Latency depends on the table: a search reads the entries one at a time, and a split or a
// merge moves entries one at a time by a step, a read and a write; a grow-and-free resize
// searches, splits, searches again and merges. An unused code or a zero-size allocate goes
// from S_IDLE straight to S_DONE, which registers its result. One request at a time:
// busy rises after accept and falls in the strobe cycle, when the next request may be
// accepted. No receiver stall. Synchronous reset restores one free block spanning the heap.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_func,
  input  wire logic [FIELD_W-1:0]  in_request_bytes,
  input  wire logic                in_has_block,
  input  wire logic [FIELD_W-1:0]  in_block_offset,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [FIELD_W-1:0]       out_result_offset,
  output logic [FIELD_W-1:0]       out_copy_from,
  output logic [FIELD_W-1:0]       out_copy_bytes
);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  // Offsets are kept wide enough for the heap; outputs take the low 20 bits.
  localparam int unsigned AW = $clog2(HEAP_BYTES + 1) + 1;
  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_ALLOC, S_SPLIT, S_MFREE, S_MERGE, S_MSHIFT,
    S_POST, S_FINDOLD, S_DONE
  } state_t;

  // Memories: a read at one address and a write at one address per cycle.
  logic [AW-1:0] start_mem [MAX_BLOCKS];
  logic [AW-1:0] size_mem  [MAX_BLOCKS];
  logic          free_mem  [MAX_BLOCKS];

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] i_r;        // walk index
  logic [CW-1:0] k_r;        // shift index
  logic [IW-1:0] tgt_r;      // entry under work
  logic          rd_v_r;     // read data valid for address i_r
  logic [AW-1:0] rd_start_r, rd_size_r;
  logic          rd_free_r;
  logic [AW-1:0] prev_size_r; // size of entry i during merge
  logic          prev_free_r;
  logic [1:0]    func_r;
  logic [AW-1:0] need_r, boff_r;
  logic          req_zero_r;
  logic [1:0]    status_r;
  logic [AW-1:0] roff_r, cfrom_r, cbytes_r;
  logic [AW-1:0] old_start_r;
  logic          grow_r;     // allocate part of a moving resize
  logic          free_tail_r; // free old block after a grow
  logic [AW-1:0] spl_start_r, spl_size_r;
  logic [IW-1:0] spl_i_r;
  logic          spl_phase_r;
  logic          alloc_mark_r;

  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [AW-1:0] wstart, wsize;
  logic          wfree;
  logic          wsz_only, wfree_only;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      if (!wfree_only) begin
        size_mem[waddr] <= wsize;
        if (!wsz_only) start_mem[waddr] <= wstart;
      end
      if (!wsz_only) free_mem[waddr] <= wfree;
    end
    rd_start_r <= start_mem[raddr];
    rd_size_r  <= size_mem[raddr];
    rd_free_r  <= free_mem[raddr];
  end

  logic [AW:0] need_ext;
  assign need_ext = {1'b0, AW'(in_request_bytes) + AW'(ALIGN_BYTES - 1)}
                    & ~(AW+1)'(ALIGN_BYTES - 1);

  always_comb begin
    raddr = i_r[IW-1:0];
    if (state_r == S_SPLIT || state_r == S_MSHIFT) raddr = k_r[IW-1:0];
  end

  // A split shifts entries up from the top, one entry at a time by a step, a read and a write.
  // A merge walks pairs and shifts the tail down.
  always_ff @(posedge clk) begin
    we <= 1'b0;
    wsz_only <= 1'b0;
    wfree_only <= 1'b0;
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      we <= 1'b1;
      waddr <= '0;
      wstart <= '0;
      wsize <= AW'(HEAP_BYTES - HEADER_BYTES);
      wfree <= 1'b1;
      rd_v_r <= 1'b0;
      spl_phase_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r <= in_func;
            need_r <= need_ext[AW-1:0];
            req_zero_r <= (in_request_bytes == '0);
            boff_r <= AW'(in_block_offset);
            status_r <= ST_NULL;
            roff_r <= '0; cfrom_r <= '0; cbytes_r <= '0;
            grow_r <= 1'b0; free_tail_r <= 1'b0;
            i_r <= '0; rd_v_r <= 1'b0;
            spl_phase_r <= 1'b0;
            if (in_func == FUNC_ALLOC || (in_func == FUNC_RESIZE && !in_has_block)) begin
              state_r <= (in_request_bytes == '0) ? S_DONE : S_ALLOC;
            end else if (in_func == FUNC_FREE) begin
              if (!in_has_block) begin
                status_r <= ST_DONE;
                state_r <= S_DONE;
              end else state_r <= S_FIND;
            end else if (in_func == FUNC_RESIZE) state_r <= S_FIND;
            else state_r <= S_DONE;
          end
        end
        S_FIND: begin
          if (i_r >= count_r) begin
            status_r <= ST_NOBLK;
            state_r <= S_DONE;
          end else if (!rd_v_r) rd_v_r <= 1'b1;
          else if (rd_start_r + HDR == boff_r) begin
            tgt_r <= i_r[IW-1:0];
            rd_v_r <= 1'b0;
            if (func_r == FUNC_FREE || req_zero_r) begin
              status_r <= (func_r == FUNC_FREE) ? ST_DONE : ST_NULL;
              state_r <= S_MFREE;
            end else if (need_r <= rd_size_r) begin
              status_r <= ST_DONE;
              roff_r <= rd_start_r + HDR;
              spl_start_r <= rd_start_r; spl_size_r <= rd_size_r;
              spl_i_r <= i_r[IW-1:0];
              alloc_mark_r <= 1'b0;
              k_r <= count_r; spl_phase_r <= 1'b0;
              state_r <= S_SPLIT;
            end else begin
              old_start_r <= rd_start_r;
              cbytes_r <= rd_size_r;
              grow_r <= 1'b1;
              i_r <= '0;
              state_r <= S_ALLOC;
            end
          end else begin
            i_r <= i_r + CW'(1);
            rd_v_r <= 1'b0;
          end
        end
        S_ALLOC: begin
          if (i_r >= count_r) begin
            status_r <= ST_NULL;
            cbytes_r <= '0;
            state_r <= S_DONE;
          end else if (!rd_v_r) rd_v_r <= 1'b1;
          else if (rd_free_r && rd_size_r >= need_r) begin
            status_r <= ST_DONE;
            roff_r <= rd_start_r + HDR;
            spl_start_r <= rd_start_r; spl_size_r <= rd_size_r;
            spl_i_r <= i_r[IW-1:0];
            alloc_mark_r <= 1'b1;
            k_r <= count_r; spl_phase_r <= 1'b0;
            if (grow_r) begin
              cfrom_r <= old_start_r + HDR;
              free_tail_r <= 1'b1;
            end
            rd_v_r <= 1'b0;
            state_r <= S_SPLIT;
          end else begin
            i_r <= i_r + CW'(1);
            rd_v_r <= 1'b0;
          end
        end
        S_SPLIT: begin
          if (count_r >= CW'(MAX_BLOCKS) ||
              {1'b0, spl_size_r} < {1'b0, need_r} + (AW+1)'(HEADER_BYTES + MIN_REMAINDER)) begin
            if (alloc_mark_r) begin
              we <= 1'b1; wfree_only <= 1'b1; waddr <= spl_i_r; wfree <= 1'b0;
            end
            state_r <= S_POST;
          end else if (spl_phase_r) begin
            // Read k then write it to k+1.
            if (!rd_v_r) rd_v_r <= 1'b1;
            else begin
              we <= 1'b1; waddr <= IW'(k_r + CW'(1));
              wstart <= rd_start_r; wsize <= rd_size_r; wfree <= rd_free_r;
              rd_v_r <= 1'b0;
              spl_phase_r <= 1'b0;
            end
          end else if (k_r > CW'(spl_i_r) + CW'(1)) begin
            k_r <= k_r - CW'(1);
            spl_phase_r <= 1'b1;
          end else begin
            // k_r == i+1: write the remainder, then shrink entry i.
            we <= 1'b1; waddr <= IW'(spl_i_r + IW'(1));
            wstart <= spl_start_r + HDR + need_r;
            wsize <= spl_size_r - need_r - HDR;
            wfree <= 1'b1;
            count_r <= count_r + CW'(1);
            spl_size_r <= '0;
            k_r <= '0;
            state_r <= S_MFREE;
            tgt_r <= spl_i_r;
            free_tail_r <= free_tail_r; // unchanged
            prev_free_r <= 1'b1; // overwritten in S_MERGE before use
            grow_r <= grow_r;
            i_r <= CW'(spl_i_r);
            spl_phase_r <= 1'b1;
          end
        end
        S_MFREE: begin
          if (spl_phase_r) begin
            // Shrink entry after split, marking it used for an allocate.
            we <= 1'b1; waddr <= tgt_r; wsz_only <= !alloc_mark_r;
            wstart <= spl_start_r; wsize <= need_r; wfree <= 1'b0;
            spl_phase_r <= 1'b0;
            state_r <= S_POST;
          end else begin
            we <= 1'b1; wfree_only <= 1'b1; waddr <= tgt_r; wfree <= 1'b1;
            i_r <= '0; rd_v_r <= 1'b0; k_r <= '0;
            state_r <= S_MERGE;
          end
        end
        S_POST: begin
          if (free_tail_r) begin
            free_tail_r <= 1'b0;
            i_r <= '0; rd_v_r <= 1'b0; boff_r <= old_start_r + HDR;
            func_r <= FUNC_FREE; req_zero_r <= 1'b1;
            state_r <= S_FINDOLD;
          end else state_r <= S_DONE;
        end
        S_FINDOLD: begin
          if (i_r >= count_r) state_r <= S_DONE;
          else if (!rd_v_r) rd_v_r <= 1'b1;
          else if (rd_start_r + HDR == boff_r) begin
            tgt_r <= i_r[IW-1:0]; rd_v_r <= 1'b0;
            spl_phase_r <= 1'b0;
            state_r <= S_MFREE;
          end else begin
            i_r <= i_r + CW'(1); rd_v_r <= 1'b0;
          end
        end
        S_MERGE: begin
          // Codes 0 and 1 read entry i; codes 2 and 3 read entry i+1 with i_r moved up.
          // Code 0 first sets rd_v_r and only then moves on, so the free mark just written is seen.
          if ((k_r < CW'(2)) ? (i_r + CW'(1) >= count_r) : (i_r >= count_r))
            state_r <= S_DONE;
          else if (k_r == CW'(0)) begin
            if (!rd_v_r) rd_v_r <= 1'b1;
            else k_r <= CW'(1);
          end else if (k_r == CW'(1)) begin
            prev_size_r <= rd_size_r; prev_free_r <= rd_free_r;
            i_r <= i_r + CW'(1); k_r <= CW'(2);
          end else if (k_r == CW'(2)) begin
            k_r <= CW'(3);
          end else begin
            if (prev_free_r && rd_free_r) begin
              we <= 1'b1; wsz_only <= 1'b1;
              waddr <= IW'(i_r - CW'(1));
              wsize <= prev_size_r + HDR + rd_size_r;
              prev_size_r <= prev_size_r + HDR + rd_size_r;
              k_r <= i_r;
              spl_phase_r <= 1'b0;
              state_r <= S_MSHIFT;
            end else begin
              prev_size_r <= rd_size_r; prev_free_r <= rd_free_r;
              i_r <= i_r + CW'(1); k_r <= CW'(2);
            end
          end
        end
        S_MSHIFT: begin
          // Move entries k+1.. down by one; i_r points at the removed slot.
          if (spl_phase_r) begin
            if (!rd_v_r) rd_v_r <= 1'b1;
            else begin
              we <= 1'b1; waddr <= IW'(k_r - CW'(1));
              wstart <= rd_start_r; wsize <= rd_size_r; wfree <= rd_free_r;
              spl_phase_r <= 1'b0; rd_v_r <= 1'b0;
            end
          end else if (k_r + CW'(1) >= count_r) begin
            count_r <= count_r - CW'(1);
            k_r <= CW'(2);
            state_r <= S_MERGE;
          end else begin
            k_r <= k_r + CW'(1); spl_phase_r <= 1'b1; rd_v_r <= 1'b0;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_status <= status_r;
          out_result_offset <= FIELD_W'(roff_r);
          out_copy_from <= FIELD_W'(cfrom_r);
          out_copy_bytes <= FIELD_W'(cbytes_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(1) && count_r <= CW'(MAX_BLOCKS))
    else $error("entry count out of range");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy || $past(state_r) == S_DONE)
    else $error("result outside done");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_UNUSED)
    else $error("bad status");
`endif
endmodule
`default_nettype wire
